[sv/gdd_pkg.sv]
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared widths, types and constants for the Gregorian day difference unit.
// ----------------------------------------------------------------------------
package gdd_pkg;

	// Field and internal widths
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int MSTART_W = 9;   // cumulative month offset, up to 334
	localparam int DOY_W    = 10;  // offset plus day, up to 365
	localparam int DAYS_W   = 23;  // day count from start of year 0
	localparam int DIFF_W   = 23;  // signed result width
	localparam int YSUM_W   = YEAR_W + 1;

	// n / 100 == (n * 5243) >> 19 holds exactly for n below 43690
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = 29;
	localparam int CENT_W      = 8;   // quotients by 100 stay below 256
	localparam int QUAD_W      = 6;   // quotients by 400 stay below 64

	localparam int DAYS_PER_YEAR = 365;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef logic [DAYS_W-1:0] days_t;

	// Per-stage load enables of the date pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// Days in the year before the first of month m (m already clamped)
	function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [MSTART_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[sv/gdd_date_count.sv]
// ----------------------------------------------------------------------------
// gdd_date_count
// Three-stage pipeline turning one date into a day count from year 0.
// ----------------------------------------------------------------------------
module gdd_date_count import gdd_pkg::*; #(
	parameter int YEAR_LIMIT = 9999
) (
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [DAY_W-1:0]   day,
	input  logic [MONTH_W-1:0] month,
	input  logic [YEAR_W-1:0]  year,
	output days_t              count
);

	// Stage 1: clamp month and year, look up month offset
	logic [MONTH_W-1:0]  month_c;
	logic [YEAR_W-1:0]   year_c;
	logic [DAY_W-1:0]    day_s1;
	logic [MSTART_W-1:0] mstart_s1;
	logic                late_s1;
	logic [YEAR_W-1:0]   year_s1;

	always_comb begin
		if (month < MONTH_JAN)
			month_c = MONTH_JAN;
		else if (month > MONTH_DEC)
			month_c = MONTH_DEC;
		else
			month_c = month;
		if (32'(year) > YEAR_LIMIT)
			year_c = YEAR_W'(YEAR_LIMIT);
		else
			year_c = year;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			day_s1    <= day;
			mstart_s1 <= month_start(month_c);
			late_s1   <= (month_c > MONTH_FEB);
			year_s1   <= year_c;
		end
	end

	// Stage 2: quotients by 100 and 400 via reciprocal multiply, 365*y + ceil(y/4)
	logic [YSUM_W-1:0] yp3, yp99, yp399;
	logic [PROD_W-1:0] prod_h, prod_c100, prod_c400;
	logic [CENT_W-1:0] cent_s2, c100_s2;
	logic [QUAD_W-1:0] c400_s2;
	days_t             base_s2;
	logic [DOY_W-1:0]  doy_s2;
	logic              late_s2;
	logic [YEAR_W-1:0] year_s2;

	always_comb begin
		yp3       = YSUM_W'(year_s1) + YSUM_W'(3);
		yp99      = YSUM_W'(year_s1) + YSUM_W'(99);
		yp399     = YSUM_W'(year_s1) + YSUM_W'(399);
		prod_h    = PROD_W'(year_s1) * PROD_W'(RECIP_100);
		prod_c100 = PROD_W'(yp99) * PROD_W'(RECIP_100);
		prod_c400 = PROD_W'(yp399[YSUM_W-1:2]) * PROD_W'(RECIP_100);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cent_s2 <= prod_h[RECIP_SHIFT +: CENT_W];
			c100_s2 <= prod_c100[RECIP_SHIFT +: CENT_W];
			c400_s2 <= prod_c400[RECIP_SHIFT +: QUAD_W];
			base_s2 <= DAYS_W'(year_s1) * DAYS_W'(DAYS_PER_YEAR)
				+ DAYS_W'(yp3[YSUM_W-1:2]);
			doy_s2  <= DOY_W'(mstart_s1) + DOY_W'(day_s1);
			late_s2 <= late_s1;
			year_s2 <= year_s1;
		end
	end

	// Stage 3: leap test and final sum
	logic [YEAR_W-1:0] rem100;
	logic              leap;
	days_t             count_s3;

	always_comb begin
		rem100 = year_s2 - YEAR_W'(YEAR_W'(cent_s2) * YEAR_W'(100));
		leap   = (year_s2[1:0] == 2'b00) && ((rem100 != '0) || (cent_s2[1:0] == 2'b00));
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			count_s3 <= base_s2 - DAYS_W'(c100_s2) + DAYS_W'(c400_s2)
				+ DAYS_W'(doy_s2) + DAYS_W'(late_s2 && leap);
		end
	end

	assign count = count_s3;

endmodule

[sv/gregorian_day_difference_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_day_difference_unit
// Signed day count from a first Gregorian date to a second one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries two dates, each as day,
//   month and year. Output channel (out_valid / out_stall) carries
//   day_difference, second date minus first, saturated to 23 bits signed.
//   Month is clamped to 1..12, year to YEAR_LIMIT; the day is not checked.
//   Four register stages: three in the date pipeline (clamp and table,
//   reciprocal multiplies, leap test and sum) and one subtract-and-saturate
//   stage. out_valid rises once an item is loaded into the last stage, and
//   the output transfer takes place at an edge where out_stall is low.
//   Throughput is one pair of dates per cycle while out_stall is low.
//   When the receiver stalls, the result holds and the stages behind it
//   fill up; empty stages keep loading, so in_stall rises only once every
//   stage holds an item. Nothing is dropped or repeated.
//   Reset clears all valid bits, so in_stall is low and the block can take
//   an item as soon as reset is released.
// ----------------------------------------------------------------------------
module gregorian_day_difference_unit import gdd_pkg::*; #(
	parameter int YEAR_LIMIT = 9999
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [DAY_W-1:0]         first_day,
	input  logic [MONTH_W-1:0]       first_month,
	input  logic [YEAR_W-1:0]        first_year,
	input  logic [DAY_W-1:0]         second_day,
	input  logic [MONTH_W-1:0]       second_month,
	input  logic [YEAR_W-1:0]        second_year,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DIFF_W-1:0] day_difference
);

	localparam int SUB_W = DAYS_W + 1;
	localparam logic signed [SUB_W-1:0] OUT_MAX = SUB_W'((1 << (DIFF_W - 1)) - 1);
	localparam logic signed [SUB_W-1:0] OUT_MIN = -SUB_W'(1 << (DIFF_W - 1));

	// Valid bits and stage enables; a stage loads when empty or draining
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      en_s4;
	stage_en_t en;

	always_comb begin
		en_s4 = !v_s4 || !out_stall;
		en.s3 = !v_s3 || en_s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Day counts of both dates
	days_t count_a, count_b;

	gdd_date_count #(.YEAR_LIMIT(YEAR_LIMIT)) u_first (
		.clk   (clk),
		.en    (en),
		.day   (first_day),
		.month (first_month),
		.year  (first_year),
		.count (count_a)
	);

	gdd_date_count #(.YEAR_LIMIT(YEAR_LIMIT)) u_second (
		.clk   (clk),
		.en    (en),
		.day   (second_day),
		.month (second_month),
		.year  (second_year),
		.count (count_b)
	);

	// Stage 4: subtract and saturate
	logic signed [SUB_W-1:0]  diff;
	logic signed [DIFF_W-1:0] diff_sat;
	logic signed [DIFF_W-1:0] diff_s4;

	always_comb begin
		diff = $signed({1'b0, count_b}) - $signed({1'b0, count_a});
		if (diff > OUT_MAX)
			diff_sat = OUT_MAX[DIFF_W-1:0];
		else if (diff < OUT_MIN)
			diff_sat = OUT_MIN[DIFF_W-1:0];
		else
			diff_sat = diff[DIFF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s4) diff_s4 <= diff_sat;
	end

	assign in_stall       = !en.s1;
	assign out_valid      = v_s4;
	assign day_difference = diff_s4;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gregorian_day_difference_unit. A scoreboard class
// predicts the signed day difference of every accepted pair of dates and
// checks each result in order. Directed dates cover field extremes, leap
// rules, clamped months and years, and unchecked days. Random pairs follow.
// The sender works in bursts and the receiver stalls on changing patterns,
// with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import gdd_pkg::*;

	localparam int YEAR_CAP     = 9999;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 60;

	// Scoreboard: predicts day differences and matches them against results
	class day_diff_scoreboard;
		logic signed [DIFF_W-1:0] pending_diffs[$];
		int mismatches;
		int results_seen;

		function new();
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function bit leap_year(int unsigned y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		// Days from the start of year 0 up to and including the given date
		function longint day_number(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
				logic [YEAR_W-1:0] y);
			int unsigned cum_days[12];
			int unsigned mm;
			int unsigned yy;
			longint doy;
			cum_days = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
			mm = m;
			yy = y;
			if (mm < MONTH_JAN) mm = MONTH_JAN;
			if (mm > MONTH_DEC) mm = MONTH_DEC;
			if (yy > YEAR_CAP) yy = YEAR_CAP;
			doy = cum_days[mm - 1] + d;
			if (mm > MONTH_FEB && leap_year(yy)) doy++;
			return longint'(DAYS_PER_YEAR) * yy + (yy + 3) / 4 - (yy + 99) / 100
				+ (yy + 399) / 400 + doy;
		endfunction

		// Note an accepted input transfer
		function void note_dates(logic [DAY_W-1:0] d1, logic [MONTH_W-1:0] m1,
				logic [YEAR_W-1:0] y1, logic [DAY_W-1:0] d2,
				logic [MONTH_W-1:0] m2, logic [YEAR_W-1:0] y2);
			longint diff;
			diff = day_number(d2, m2, y2) - day_number(d1, m1, y1);
			if (diff > 4194303) diff = 4194303;
			if (diff < -4194304) diff = -4194304;
			pending_diffs.push_back(diff[DIFF_W-1:0]);
		endfunction

		// Check an accepted output transfer against the oldest prediction
		function void check_diff(logic signed [DIFF_W-1:0] got);
			logic signed [DIFF_W-1:0] want;
			results_seen++;
			if (pending_diffs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %0d", $time, got);
				return;
			end
			want = pending_diffs.pop_front();
			if (got !== want) begin
				mismatches++;
				$display("%0t: day_difference mismatch, expected %0d, actual %0d",
					$time, want, got);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [DAY_W-1:0]         first_day;
	logic [MONTH_W-1:0]       first_month;
	logic [YEAR_W-1:0]        first_year;
	logic [DAY_W-1:0]         second_day;
	logic [MONTH_W-1:0]       second_month;
	logic [YEAR_W-1:0]        second_year;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DIFF_W-1:0] day_difference;

	day_diff_scoreboard sb;

	gregorian_day_difference_unit #(
		.YEAR_LIMIT(YEAR_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_day(first_day),
		.first_month(first_month),
		.first_year(first_year),
		.second_day(second_day),
		.second_month(second_month),
		.second_year(second_year),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.day_difference(day_difference)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_diff(day_difference);
	end

	// Offer one pair of dates; called at a falling edge, returns at one
	task automatic send_dates(input int d1, input int m1, input int y1,
			input int d2, input int m2, input int y2);
		first_day    = d1[DAY_W-1:0];
		first_month  = m1[MONTH_W-1:0];
		first_year   = y1[YEAR_W-1:0];
		second_day   = d2[DAY_W-1:0];
		second_month = m2[MONTH_W-1:0];
		second_year  = y2[YEAR_W-1:0];
		in_valid     = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_dates(first_day, first_month, first_year,
			second_day, second_month, second_year);
		@(negedge clk);
	endtask

	// Idle the input for a number of cycles
	task automatic idle_input(input int cycles);
		if (cycles > 0) begin
			in_valid = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	function automatic int month_length(int m, int y);
		int lens[12];
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == MONTH_FEB && sb.leap_year(y)) return 29;
		return lens[m - 1];
	endfunction

	// Pick a year, biased toward the range ends, leap years and century boundaries
	function automatic int pick_year();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? 0 : YEAR_CAP;
			1:       return $urandom_range(0, 99) * 100 + $urandom_range(0, 2) - 1 + 1;
			2:       return $urandom_range(0, 2499) * 4;
			default: return $urandom_range(0, YEAR_CAP);
		endcase
	endfunction

	// Random pair: mostly real dates, some broken days and raw noise
	task automatic send_random_pair();
		int d1, m1, y1, d2, m2, y2;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			d1 = $urandom; m1 = $urandom; y1 = $urandom;
			d2 = $urandom; m2 = $urandom; y2 = $urandom;
		end else begin
			y1 = pick_year();
			if ($urandom_range(0, 2) == 0) begin
				y2 = y1 + $urandom_range(0, 6) - 3;
				if (y2 < 0) y2 = 0;
				if (y2 > YEAR_CAP) y2 = YEAR_CAP;
			end else begin
				y2 = pick_year();
			end
			m1 = $urandom_range(1, 12);
			m2 = $urandom_range(1, 12);
			if (kind == 2) begin
				d1 = $urandom_range(0, 31);
				d2 = $urandom_range(0, 31);
			end else begin
				d1 = $urandom_range(1, month_length(m1, y1));
				d2 = $urandom_range(1, month_length(m2, y2));
			end
		end
		send_dates(d1, m1, y1, d2, m2, y2);
	endtask

	// Receiver: stall pattern changes every segment, one long hold-off
	initial begin
		int mode;
		int seg;
		int phase;
		bit held;
		out_stall = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 100);
			phase = 0;
			repeat (seg) begin
				@(negedge clk);
				if (!held && sb.results_seen >= 300) begin
					held = 1'b1;
					out_stall = 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = ((phase % 5) < 2);
				endcase
				phase++;
			end
		end
	end

	// Stimulus
	initial begin
		int burst;
		int sent;
		sb = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		first_day    = '0;
		first_month  = '0;
		first_year   = '0;
		second_day   = '0;
		second_month = '0;
		second_year  = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, leap rules, clamping, unchecked days
		send_dates(1, 1, 0, 31, 12, 9999);
		send_dates(31, 12, 9999, 1, 1, 0);
		send_dates(15, 6, 2024, 15, 6, 2024);
		send_dates(28, 2, 2000, 1, 3, 2000);
		send_dates(28, 2, 1900, 1, 3, 1900);
		send_dates(28, 2, 2004, 1, 3, 2004);
		send_dates(28, 2, 2100, 1, 3, 2100);
		send_dates(31, 2, 2023, 3, 3, 2023);
		send_dates(0, 1, 2023, 1, 1, 2023);
		send_dates(0, 3, 400, 31, 2, 400);
		send_dates(5, 0, 1999, 5, 1, 1999);
		send_dates(5, 13, 1999, 5, 12, 1999);
		send_dates(31, 15, 1600, 31, 14, 1600);
		send_dates(1, 1, 10000, 1, 1, 9999);
		send_dates(31, 12, 16383, 1, 1, 0);
		send_dates(1, 1, 0, 31, 15, 16383);
		send_dates(1, 3, 0, 1, 3, 1);
		send_dates(31, 12, 1999, 1, 1, 2000);
		send_dates(29, 2, 2400, 29, 2, 2404);
		send_dates(31, 0, 8191, 0, 15, 5461);
		send_dates(10, 10, 10922, 21, 5, 2730);
		idle_input(3);

		// Random pairs in bursts with random gaps
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				send_random_pair();
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_input($urandom_range(0, 8));
		end
		in_valid = 1'b0;

		// Drain, then allow the pipeline latency to pass
		while (sb.pending_diffs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
